/* hw/rtl/wfe_pkg.sv */
// Shared types and constants for the LED frame encoder with hue conversion.
// No dependencies; imported by wfe_hue, wfe_store and the top level.
`default_nettype none

package wfe_pkg;

   // Default size of the colour store.
   localparam int MAX_LEDS_DEFAULT = 16;

   // Fixed field widths.
   localparam int DUTY_W  = 8;
   localparam int LATCH_W = 10;
   localparam int COUNT_W = 5;
   localparam int HUE_W   = 12;
   localparam int COLOUR_W = 24;
   localparam int BITPTR_W = 5;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 16;

   // Register reset values.
   localparam logic [DUTY_W-1:0]  HIGH_DUTY_RESET   = 8'd30;
   localparam logic [DUTY_W-1:0]  LOW_DUTY_RESET    = 8'd15;
   localparam logic [LATCH_W-1:0] LATCH_SLOTS_RESET = 10'd300;
   localparam logic [COUNT_W-1:0] LED_COUNT_RESET   = 5'd9;

   // Position of the first bit sent for each LED.
   localparam logic [BITPTR_W-1:0] BIT_TOP = 5'd23;

   // Request operation codes.
   localparam logic [1:0] OP_SET_RGB = 2'd0;
   localparam logic [1:0] OP_SET_HUE = 2'd1;
   localparam logic [1:0] OP_START   = 2'd2;
   localparam logic [1:0] OP_TICK    = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_DUTY   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_DUTY    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LATCH_SLOTS = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_COUNT   = 8'd3;

   // Hue wheel constants.
   localparam logic [HUE_W-1:0] HUE_WRAP_LIMIT = 12'd1535;
   localparam logic [HUE_W-1:0] HUE_TURN       = 12'd1536;
   localparam logic [7:0]       CHAN_FULL      = 8'd255;

   // One colour as three channels.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

endpackage

`default_nettype wire

/* hw/rtl/wfe_hue.sv */
// Hue to RGB conversion on a 1536-step wheel of six linear ramps.
// Depends on wfe_pkg for the hue constants and the rgb_type struct.
`default_nettype none

module wfe_hue (
   input  wire logic [wfe_pkg::HUE_W-1:0] hue,
   output wfe_pkg::rgb_type               rgb
);
   import wfe_pkg::*;

   logic [HUE_W-1:0] hue_wrapped;
   logic [3:0]       hue_bin;
   logic [7:0]       hue_pos;

   // Fold one turn off the top of the range, then split into ramp and position.
   always_comb begin
      hue_wrapped = (hue > HUE_WRAP_LIMIT) ? hue - HUE_TURN : hue;
      hue_bin     = hue_wrapped[11:8];
      hue_pos     = hue_wrapped[7:0];
   end

   // Each ramp holds one channel full, one ramping and one off; beyond the wheel is white.
   always_comb begin
      rgb = '0;
      case (hue_bin)
         4'd0: begin
            rgb.red   = CHAN_FULL;
            rgb.green = hue_pos;
         end
         4'd1: begin
            rgb.green = CHAN_FULL;
            rgb.red   = CHAN_FULL - hue_pos;
         end
         4'd2: begin
            rgb.green = CHAN_FULL;
            rgb.blue  = hue_pos;
         end
         4'd3: begin
            rgb.blue  = CHAN_FULL;
            rgb.green = CHAN_FULL - hue_pos;
         end
         4'd4: begin
            rgb.blue  = CHAN_FULL;
            rgb.red   = hue_pos;
         end
         4'd5: begin
            rgb.red   = CHAN_FULL;
            rgb.blue  = CHAN_FULL - hue_pos;
         end
         default: begin
            rgb.red   = CHAN_FULL;
            rgb.green = CHAN_FULL;
            rgb.blue  = CHAN_FULL;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/wfe_store.sv */
// Per-LED colour store: one write port, one read port with registered data.
// Depends on wfe_pkg for the colour width; entries never written read as zero.
`default_nettype none

module wfe_store #(
   parameter int MAX_LEDS = wfe_pkg::MAX_LEDS_DEFAULT,
   localparam int PW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [PW-1:0]                 wr_addr,
   input  wire logic [wfe_pkg::COLOUR_W-1:0]  wr_data,
   input  wire logic                          rd_en,
   input  wire logic [PW-1:0]                 rd_addr,
   output logic      [wfe_pkg::COLOUR_W-1:0]  rd_data
);
   import wfe_pkg::*;

   logic [COLOUR_W-1:0] mem [MAX_LEDS];
   logic [MAX_LEDS-1:0] valid_ff;
   logic [COLOUR_W-1:0] rd_q_ff;
   logic                rd_hit_ff;

   // Storage array and its registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // One valid bit per entry, so reset empties the store at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   // An entry that has never been written reads as black.
   assign rd_data = rd_hit_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

/* hw/rtl/ws2812_frame_encoder_with_hue_core.sv */
// Frame encoder for a chain of serial RGB LEDs. Set requests write one LED's colour, either as
// RGB or from a hue, into a store held in GRB order; a start request opens a frame and every
// tick request returns one PWM slot: latch_slots zero slots, 24 slots per LED, MSB first, then
// latch_slots zero slots, with last on the final one. One request is accepted in every clock
// cycle unless the skid stage is full while the response is stalled. The frame counters advance
// at a tick's acceptance while the store is read, and the duty is formed from the read data as
// the skid entry moves into the response register. A skid stage lets one further request in
// while a response waits. Configuration writes are taken at any time, also during a frame, and
// are meant to be issued while no tick is still waiting for its response.
// Depends on wfe_pkg, wfe_hue and wfe_store.
`default_nettype none

module ws2812_frame_encoder_with_hue_core #(
   parameter int MAX_LEDS = wfe_pkg::MAX_LEDS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [1:0]                      req_op,
   input  wire logic [3:0]                      req_led_index,
   input  wire logic [7:0]                      req_red,
   input  wire logic [7:0]                      req_green,
   input  wire logic [7:0]                      req_blue,
   input  wire logic [wfe_pkg::HUE_W-1:0]       req_hue,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [wfe_pkg::DUTY_W-1:0]      rsp_duty,
   output logic                                 rsp_active,
   output logic                                 rsp_last,
   // configuration channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [wfe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [wfe_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wfe_pkg::*;

   localparam int PW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int NW  = $clog2(MAX_LEDS + 1);
   localparam int CW  = (NW > COUNT_W) ? NW : COUNT_W;
   localparam int IXW = $clog2(MAX_LEDS + 1) + 4;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEAD,
      PH_DATA,
      PH_TRAIL
   } phase_type;

   // Configuration registers.
   logic [DUTY_W-1:0]  high_duty_ff;
   logic [DUTY_W-1:0]  low_duty_ff;
   logic [LATCH_W-1:0] latch_slots_ff;
   logic [COUNT_W-1:0] led_count_ff;

   // Frame sequencer.
   phase_type          phase_ff, phase_in;
   logic [LATCH_W-1:0] slot_ff, slot_in;
   logic [PW-1:0]      led_ff, led_in;
   logic [BITPTR_W-1:0] bit_ff, bit_in;

   // Skid stage that meets the store read data.
   logic                a_valid_ff;
   logic                a_data_ff;
   logic                a_active_ff;
   logic                a_last_ff;
   logic [BITPTR_W-1:0] a_bit_ff;

   // Response register.
   logic               rsp_valid_ff;
   logic [DUTY_W-1:0]  rsp_duty_ff;
   logic               rsp_active_ff;
   logic               rsp_last_ff;

   logic               req_fire;
   logic               tick_fire;
   logic               a_move;
   logic               slot_active, slot_last, slot_data;
   logic [LATCH_W-1:0] slot_next;
   logic [CW-1:0]      frame_leds;
   logic [CW-1:0]      led_next_ext;
   logic               led_is_final;

   logic               wr_en;
   logic [PW-1:0]      wr_addr;
   logic [COLOUR_W-1:0] wr_data;
   logic               idx_in_range;
   rgb_type            hue_rgb;
   logic [COLOUR_W-1:0] rd_word;
   logic               rd_bit;

   // Handshakes: the skid stage frees when the response register can take its content.
   assign a_move    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = a_valid_ff && !a_move;
   assign req_fire  = req_valid && !req_stall;
   assign tick_fire = req_fire && (req_op == OP_TICK);
   assign csr_ready = 1'b1;

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         high_duty_ff   <= HIGH_DUTY_RESET;
         low_duty_ff    <= LOW_DUTY_RESET;
         latch_slots_ff <= LATCH_SLOTS_RESET;
         led_count_ff   <= LED_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HIGH_DUTY:   high_duty_ff   <= csr_wdata[DUTY_W-1:0];
            CSR_LOW_DUTY:    low_duty_ff    <= csr_wdata[DUTY_W-1:0];
            CSR_LATCH_SLOTS: latch_slots_ff <= csr_wdata[LATCH_W-1:0];
            CSR_LED_COUNT:   led_count_ff   <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Number of LEDs in a frame, clamped to the store size and at least one.
   always_comb begin
      frame_leds = CW'(led_count_ff);
      if (frame_leds == '0) begin
         frame_leds = CW'(1);
      end else if (frame_leds > CW'(MAX_LEDS)) begin
         frame_leds = CW'(MAX_LEDS);
      end
      led_next_ext = CW'(led_ff) + CW'(1);
      led_is_final = (led_next_ext >= frame_leds);
      slot_next    = slot_ff + LATCH_W'(1);
   end

   // Sequencer next state, evaluated for an accepted start or tick.
   always_comb begin
      phase_in    = phase_ff;
      slot_in     = slot_ff;
      led_in      = led_ff;
      bit_in      = bit_ff;
      slot_active = 1'b0;
      slot_last   = 1'b0;
      slot_data   = 1'b0;
      if (req_fire && (req_op == OP_START)) begin
         if (phase_ff == PH_IDLE) begin
            slot_in  = '0;
            led_in   = '0;
            bit_in   = BIT_TOP;
            phase_in = (latch_slots_ff != '0) ? PH_LEAD : PH_DATA;
         end
      end else if (tick_fire) begin
         case (phase_ff)
            PH_LEAD: begin
               slot_active = 1'b1;
               slot_in     = slot_next;
               if (slot_next >= latch_slots_ff) begin
                  slot_in  = '0;
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               slot_active = 1'b1;
               slot_data   = 1'b1;
               if (bit_ff == '0) begin
                  bit_in = BIT_TOP;
                  if (led_is_final) begin
                     led_in  = '0;
                     slot_in = '0;
                     if (latch_slots_ff == '0) begin
                        slot_last = 1'b1;
                        phase_in  = PH_IDLE;
                     end else begin
                        phase_in = PH_TRAIL;
                     end
                  end else begin
                     led_in = led_ff + PW'(1);
                  end
               end else begin
                  bit_in = bit_ff - BITPTR_W'(1);
               end
            end
            PH_TRAIL: begin
               slot_active = 1'b1;
               slot_in     = slot_next;
               if (slot_next >= latch_slots_ff) begin
                  slot_last = 1'b1;
                  slot_in   = '0;
                  led_in    = '0;
                  bit_in    = BIT_TOP;
                  phase_in  = PH_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         slot_ff  <= '0;
         led_ff   <= '0;
         bit_ff   <= BIT_TOP;
      end else begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         led_ff   <= led_in;
         bit_ff   <= bit_in;
      end
   end

   // Store writes from set requests; indexes past the store are ignored.
   wfe_hue u_hue (
      .hue (req_hue),
      .rgb (hue_rgb)
   );

   always_comb begin
      logic [IXW-1:0] idx_ext;
      idx_ext      = IXW'(req_led_index);
      idx_in_range = (idx_ext < IXW'(MAX_LEDS));
      wr_addr      = idx_ext[PW-1:0];
      wr_en        = req_fire && idx_in_range &&
                     ((req_op == OP_SET_RGB) || (req_op == OP_SET_HUE));
      if (req_op == OP_SET_HUE) begin
         wr_data = {hue_rgb.green, hue_rgb.red, hue_rgb.blue};
      end else begin
         wr_data = {req_green, req_red, req_blue};
      end
   end

   wfe_store #(
      .MAX_LEDS (MAX_LEDS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (tick_fire && slot_data),
      .rd_addr (led_ff),
      .rd_data (rd_word)
   );

   // Skid stage: holds the slot description until its store word has arrived and moved on.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (tick_fire) begin
         a_valid_ff <= 1'b1;
      end else if (a_move) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_fire) begin
         a_data_ff   <= slot_data;
         a_active_ff <= slot_active;
         a_last_ff   <= slot_last;
         a_bit_ff    <= bit_ff;
      end
   end

   // Duty for a data slot from the selected colour bit.
   assign rd_bit = rd_word[a_bit_ff];

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_move) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move && a_valid_ff) begin
         rsp_duty_ff   <= a_data_ff ? (rd_bit ? high_duty_ff : low_duty_ff) : '0;
         rsp_active_ff <= a_active_ff;
         rsp_last_ff   <= a_last_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_duty   = rsp_duty_ff;
   assign rsp_active = rsp_active_ff;
   assign rsp_last   = rsp_last_ff;

   // The final slot of a frame always returns the sequencer to idle.
   a_last_goes_idle : assert property (@(posedge clock) disable iff (reset)
      (tick_fire && slot_last) |=> (phase_ff == PH_IDLE))
      else $error("sequencer not idle after final slot");

   // While sending data the bit pointer stays within one colour word.
   a_bit_in_word : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (bit_ff <= BIT_TOP))
      else $error("bit pointer outside colour word");

   // A held skid entry is not lost while the response side stalls.
   a_skid_holds : assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !a_move) |=> (a_valid_ff && $stable(a_bit_ff)))
      else $error("skid entry lost under stall");

   // A last marker is only ever reported on an active slot.
   a_last_is_active : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_active_ff)
      else $error("last flagged on an idle slot");

endmodule

`default_nettype wire
